[rtl/core/thq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_pkg
// Shared constants, types and the arctangent table of the tilt quarter block.
// ----------------------------------------------------------------------------
package thq_pkg;

   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;

   localparam int VEC_W      = 19;
   localparam int Z_INT_BITS = 10;
   localparam int MIN_MAG_W  = 15;
   localparam int MIN_SQ_W   = 30;
   localparam int HYS_W      = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MAGNITUDE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS_ANGLE = 1'b1;

   localparam logic [MIN_MAG_W-1:0] MIN_MAG_RESET = 15'd4096;
   localparam logic [HYS_W-1:0]     HYS_RESET     = 14'd2560;

   localparam int ATAN_DEG16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   localparam int QUARTER_ANGLE [4] = '{0, 270, 180, 90};

   typedef struct packed {
      logic       hold;
      logic       zero;
      logic [1:0] quarter;
   } thq_tag_type;

   function automatic int atan_step(input int stage, input int frac_bits);
      int drop;
      drop = 16 - frac_bits;
      return (ATAN_DEG16[stage] + (1 << (drop - 1))) >> drop;
   endfunction

endpackage
`default_nettype wire

[rtl/core/thq_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_prep
// Two front stages: fold the vector into the right half plane and square the
// axes, then compare the squared magnitude with the squared minimum.
// ----------------------------------------------------------------------------
module thq_prep #(
   parameter  int ANGLE_FRAC_BITS = thq_pkg::ANGLE_FRAC_BITS_DEF,
   localparam int ZW              = ANGLE_FRAC_BITS + thq_pkg::Z_INT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [15:0]                   in_accel_x,
   input  logic signed [15:0]                   in_accel_y,
   input  logic [2:0]                           in_current_quarter,
   input  logic [thq_pkg::MIN_SQ_W-1:0]         min_sq,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [thq_pkg::VEC_W-1:0]     out_x,
   output logic signed [thq_pkg::VEC_W-1:0]     out_y,
   output logic signed [ZW-1:0]                 out_z,
   output thq_pkg::thq_tag_type                 out_tag
);
   import thq_pkg::*;

   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 << ANGLE_FRAC_BITS);

   logic                    a_valid_ff;
   logic signed [VEC_W-1:0] a_x_ff;
   logic signed [VEC_W-1:0] a_y_ff;
   logic signed [ZW-1:0]    a_z_ff;
   logic [30:0]             a_sqx_ff;
   logic [30:0]             a_sqy_ff;
   thq_tag_type             a_tag_ff;
   logic                    a_ready;

   logic                    b_valid_ff;
   logic signed [VEC_W-1:0] b_x_ff;
   logic signed [VEC_W-1:0] b_y_ff;
   logic signed [ZW-1:0]    b_z_ff;
   thq_tag_type             b_tag_ff;
   logic                    b_ready;

   logic signed [VEC_W-1:0] x_ext;
   logic signed [VEC_W-1:0] y_ext;
   logic signed [31:0]      x_wide;
   logic signed [31:0]      y_wide;
   logic signed [31:0]      x_prod;
   logic signed [31:0]      y_prod;
   logic                    neg;
   logic signed [VEC_W-1:0] a_x_in;
   logic signed [VEC_W-1:0] a_y_in;
   logic signed [ZW-1:0]    a_z_in;
   thq_tag_type             a_tag_in;
   logic [31:0]             mag_sq;
   thq_tag_type             b_tag_in;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   always_comb begin
      x_ext  = VEC_W'(in_accel_x);
      y_ext  = VEC_W'(in_accel_y);
      x_wide = 32'(in_accel_x);
      y_wide = 32'(in_accel_y);
      x_prod = x_wide * x_wide;
      y_prod = y_wide * y_wide;
      neg    = in_accel_x[15];
      a_x_in = neg ? -x_ext : x_ext;
      a_y_in = neg ? -y_ext : y_ext;
      a_z_in = neg ? HALF_TURN : '0;
      a_tag_in.hold    = 1'b0;
      a_tag_in.zero    = (in_accel_x == 16'sd0) && (in_accel_y == 16'sd0);
      a_tag_in.quarter = in_current_quarter[2] ? 2'd0 : in_current_quarter[1:0];
   end

   always_comb begin
      mag_sq   = {1'b0, a_sqx_ff} + {1'b0, a_sqy_ff};
      b_tag_in = a_tag_ff;
      b_tag_in.hold = mag_sq < {2'b00, min_sq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (a_ready && in_valid) begin
         a_x_ff   <= a_x_in;
         a_y_ff   <= a_y_in;
         a_z_ff   <= a_z_in;
         a_sqx_ff <= x_prod[30:0];
         a_sqy_ff <= y_prod[30:0];
         a_tag_ff <= a_tag_in;
      end
      if (b_ready && a_valid_ff) begin
         b_x_ff   <= a_x_ff;
         b_y_ff   <= a_y_ff;
         b_z_ff   <= a_z_ff;
         b_tag_ff <= b_tag_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_x     = b_x_ff;
   assign out_y     = b_y_ff;
   assign out_z     = b_z_ff;
   assign out_tag   = b_tag_ff;

endmodule
`default_nettype wire

[rtl/core/thq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_cell
// One vectoring CORDIC cell: rotate toward the x axis by the fixed angle of
// its stage and hand the vector and angle sum to the next cell.
// ----------------------------------------------------------------------------
module thq_cell #(
   parameter  int ANGLE_FRAC_BITS = thq_pkg::ANGLE_FRAC_BITS_DEF,
   parameter  int STAGE           = 0,
   localparam int ZW              = ANGLE_FRAC_BITS + thq_pkg::Z_INT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [thq_pkg::VEC_W-1:0] in_x,
   input  logic signed [thq_pkg::VEC_W-1:0] in_y,
   input  logic signed [ZW-1:0]             in_z,
   input  thq_pkg::thq_tag_type             in_tag,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [thq_pkg::VEC_W-1:0] out_x,
   output logic signed [thq_pkg::VEC_W-1:0] out_y,
   output logic signed [ZW-1:0]             out_z,
   output thq_pkg::thq_tag_type             out_tag
);
   import thq_pkg::*;

   localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(STAGE, ANGLE_FRAC_BITS));

   logic                    valid_ff;
   logic signed [VEC_W-1:0] x_ff;
   logic signed [VEC_W-1:0] y_ff;
   logic signed [ZW-1:0]    z_ff;
   thq_tag_type             tag_ff;

   logic signed [VEC_W-1:0] xs;
   logic signed [VEC_W-1:0] ys;
   logic signed [VEC_W-1:0] x_in;
   logic signed [VEC_W-1:0] y_in;
   logic signed [ZW-1:0]    z_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs = in_x >>> STAGE;
      ys = in_y >>> STAGE;
      if (!in_y[VEC_W-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + STEP;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

`ifndef SYNTHESIS
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !x_ff[VEC_W-1])
      else $error("cordic cell x went negative");
`endif

endmodule
`default_nettype wire

[rtl/core/thq_decide.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thq_decide
// Wrap the CORDIC angle into one turn, then keep the held quarter for a weak
// sample or within hysteresis, else pick the nearest quarter; drive the result register.
// ----------------------------------------------------------------------------
module thq_decide #(
   parameter  int ANGLE_FRAC_BITS = thq_pkg::ANGLE_FRAC_BITS_DEF,
   localparam int ZW              = ANGLE_FRAC_BITS + thq_pkg::Z_INT_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [ZW-1:0]         in_z,
   input  thq_pkg::thq_tag_type         in_tag,
   input  logic [thq_pkg::HYS_W-1:0]    hysteresis_angle,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   out_new_quarter
);
   import thq_pkg::*;

   localparam int AW = ANGLE_FRAC_BITS + 9;
   localparam int SW = HYS_W + ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] FULL_ANGLE = ZW'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [ZW-1:0] HALF_ANGLE = ZW'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [ZW-1:0] BASE_BAND  = ZW'(45 << ANGLE_FRAC_BITS);

   logic              d1_valid_ff;
   logic [AW-1:0]     ang_ff;
   thq_tag_type       d1_tag_ff;
   logic              d1_ready;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_quarter_ff;
   logic              rsp_ready_int;

   logic signed [ZW-1:0] z_wrap;
   logic [AW-1:0]        ang_in;
   logic [SW-1:0]        hys_scaled;
   logic signed [ZW-1:0] band;
   logic signed [ZW-1:0] ang_ext;
   logic signed [ZW-1:0] diff [4];
   logic signed [ZW-1:0] off [4];
   logic signed [ZW-1:0] near_off;
   logic [1:0]           best;
   logic                 keep;
   logic [1:0]           rsp_quarter_in;

   assign rsp_ready_int = !rsp_valid_ff || out_ready;
   assign d1_ready      = !d1_valid_ff || rsp_ready_int;
   assign in_ready      = d1_ready;

   always_comb begin
      z_wrap = in_z[ZW-1] ? in_z + FULL_ANGLE : in_z;
      ang_in = in_tag.zero ? '0 : z_wrap[AW-1:0];
   end

   always_comb begin
      hys_scaled = {hysteresis_angle, {ANGLE_FRAC_BITS{1'b0}}};
      band       = BASE_BAND + ZW'(hys_scaled >> 8);
      ang_ext    = ZW'(ang_ff);
      for (int k = 0; k < 4; k++) begin
         diff[k] = ang_ext - ZW'(QUARTER_ANGLE[k] << ANGLE_FRAC_BITS);
         if (diff[k] > HALF_ANGLE) begin
            diff[k] = diff[k] - FULL_ANGLE;
         end else if (diff[k] <= -HALF_ANGLE) begin
            diff[k] = diff[k] + FULL_ANGLE;
         end
         off[k] = diff[k][ZW-1] ? -diff[k] : diff[k];
      end
      best     = 2'd0;
      near_off = off[0];
      for (int k = 1; k < 4; k++) begin
         if (off[k] < near_off) begin
            near_off = off[k];
            best     = 2'(k);
         end
      end
      keep = d1_tag_ff.hold || (off[d1_tag_ff.quarter] <= band);
      rsp_quarter_in = keep ? d1_tag_ff.quarter : best;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (d1_ready) begin
            d1_valid_ff <= in_valid;
         end
         if (rsp_ready_int) begin
            rsp_valid_ff <= d1_valid_ff;
         end
      end
      if (d1_ready && in_valid) begin
         ang_ff    <= ang_in;
         d1_tag_ff <= in_tag;
      end
      if (rsp_ready_int && d1_valid_ff) begin
         rsp_quarter_ff <= rsp_quarter_in;
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign out_new_quarter = rsp_quarter_ff;

`ifndef SYNTHESIS
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      d1_valid_ff |-> (ZW'(ang_ff) < FULL_ANGLE))
      else $error("wrapped angle outside one turn");

   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      (d1_valid_ff && d1_tag_ff.hold && rsp_ready_int) |=>
         (rsp_quarter_ff == $past(d1_tag_ff.quarter)))
      else $error("weak sample did not keep the held quarter");
`endif

endmodule
`default_nettype wire

[rtl/core/tilt_quarter_hysteresis.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_quarter_hysteresis
// Screen quarter from one accelerometer sample, held with hysteresis.
//
// req_ carries one sample (accel_x, accel_y) and the quarter now held; rsp_
// returns the quarter to hold, one item per request item, in order.
// csr_ writes min_magnitude (index 0) and hysteresis_angle (index 1); it is
// always ready. The user must write it only while no item is in flight; the
// block itself does not enforce this. From request accept to rsp_valid an
// item passes two front stages (fold and square, magnitude compare), one cell
// per CORDIC stage, an angle wrap stage and the result register.
// Throughput is one item per cycle while rsp_ready is high; every stage holds
// one item and moves on whenever the stage after it is empty or moving, so
// bubbles fill in. When the receiver stalls, the result register holds and
// the stages behind it fill up; req_ready drops once all CORDIC_STAGES + 4
// slots are full. Reset empties every stage and loads min_magnitude 4096 and
// hysteresis_angle 2560 (10 degrees); no clearing pass follows.
// ----------------------------------------------------------------------------
module tilt_quarter_hysteresis #(
   parameter int CORDIC_STAGES   = thq_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = thq_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [15:0]                req_accel_x,
   input  logic signed [15:0]                req_accel_y,
   input  logic [2:0]                        req_current_quarter,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_new_quarter,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [thq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import thq_pkg::*;

   localparam int ZW = ANGLE_FRAC_BITS + Z_INT_BITS;

   logic [MIN_MAG_W-1:0]    min_mag_ff;
   logic [HYS_W-1:0]        hys_ff;
   logic [MIN_SQ_W-1:0]     min_sq_ff;
   logic [2*MIN_MAG_W-1:0]  min_sq_in;

   logic                    c_valid [CORDIC_STAGES+1];
   logic                    c_ready [CORDIC_STAGES+1];
   logic signed [VEC_W-1:0] c_x     [CORDIC_STAGES+1];
   logic signed [VEC_W-1:0] c_y     [CORDIC_STAGES+1];
   logic signed [ZW-1:0]    c_z     [CORDIC_STAGES+1];
   thq_tag_type             c_tag   [CORDIC_STAGES+1];

   assign csr_ready = 1'b1;
   assign min_sq_in = min_mag_ff * min_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_mag_ff <= MIN_MAG_RESET;
         hys_ff     <= HYS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_MAGNITUDE: begin
               min_mag_ff <= csr_data[MIN_MAG_W-1:0];
            end
            CSR_HYSTERESIS_ANGLE: begin
               hys_ff <= csr_data[HYS_W-1:0];
            end
            default: begin
               min_mag_ff <= min_mag_ff;
            end
         endcase
      end
      min_sq_ff <= min_sq_in;
   end

   thq_prep #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_prep (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_valid),
      .in_ready           (req_ready),
      .in_accel_x         (req_accel_x),
      .in_accel_y         (req_accel_y),
      .in_current_quarter (req_current_quarter),
      .min_sq             (min_sq_ff),
      .out_valid          (c_valid[0]),
      .out_ready          (c_ready[0]),
      .out_x              (c_x[0]),
      .out_y              (c_y[0]),
      .out_z              (c_z[0]),
      .out_tag            (c_tag[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      thq_cell #(
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
         .STAGE           (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_x      (c_x[i]),
         .in_y      (c_y[i]),
         .in_z      (c_z[i]),
         .in_tag    (c_tag[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_x     (c_x[i+1]),
         .out_y     (c_y[i+1]),
         .out_z     (c_z[i+1]),
         .out_tag   (c_tag[i+1])
      );
   end

   thq_decide #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_decide (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (c_valid[CORDIC_STAGES]),
      .in_ready         (c_ready[CORDIC_STAGES]),
      .in_z             (c_z[CORDIC_STAGES]),
      .in_tag           (c_tag[CORDIC_STAGES]),
      .hysteresis_angle (hys_ff),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_new_quarter  (rsp_new_quarter)
   );

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while the result register is empty");
`endif

endmodule
`default_nettype wire

[test/thq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thq_checker
// Watches the request, result and register channels of the tilt quarter
// block, predicts the quarter to hold for every accepted sample, and matches
// each accepted result against the oldest prediction still open.
// ----------------------------------------------------------------------------
module thq_checker #(
   parameter int CORDIC_STAGES   = thq_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = thq_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [15:0]             req_accel_x,
   input  logic signed [15:0]             req_accel_y,
   input  logic [2:0]                     req_current_quarter,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [1:0]                     rsp_new_quarter,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [thq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [thq_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatches,
   output int                             outstanding
);
   import thq_pkg::*;

   localparam longint ARCTAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };
   localparam longint QUARTER_CENTRE [4] = '{0, 270, 180, 90};
   localparam longint HALF_TURN = longint'(180) << ANGLE_FRAC_BITS;
   localparam longint FULL_TURN = longint'(360) << ANGLE_FRAC_BITS;

   logic [MIN_MAG_W-1:0] min_mag;
   logic [HYS_W-1:0]     hys_band;
   logic [1:0]           expected_quarters [$];

   initial mismatches = 0;
   initial outstanding = 0;

   function automatic longint wrap_half_turn(input longint d);
      longint w;
      w = d;
      while (w > HALF_TURN) w = w - FULL_TURN;
      while (w <= -HALF_TURN) w = w + FULL_TURN;
      return w;
   endfunction

   function automatic longint tilt_angle(input longint ax, input longint ay);
      longint x, y, z, xs, ys, step;
      int drop;
      x = ax;
      y = ay;
      z = 0;
      drop = 16 - ANGLE_FRAC_BITS;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         step = (ARCTAN_Q16[i] + (longint'(1) << (drop - 1))) >>> drop;
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + step;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - step;
         end
      end
      while (z < 0) z = z + FULL_TURN;
      while (z >= FULL_TURN) z = z - FULL_TURN;
      return z;
   endfunction

   function automatic logic [1:0] predict_quarter(
      input logic signed [15:0] ax,
      input logic signed [15:0] ay,
      input logic [2:0]         cq,
      input logic [MIN_MAG_W-1:0] mm,
      input logic [HYS_W-1:0]   hy
   );
      longint x, y, mag2, min2, ang, band, d, off, near_off;
      logic [1:0] q, best;
      x = longint'(ax);
      y = longint'(ay);
      q = (cq > 3'd3) ? 2'd0 : cq[1:0];
      mag2 = x * x + y * y;
      min2 = longint'(mm) * longint'(mm);
      if (mag2 < min2) return q;
      ang = tilt_angle(x, y);
      band = (longint'(45) << ANGLE_FRAC_BITS) + ((longint'(hy) << ANGLE_FRAC_BITS) / 256);
      d = wrap_half_turn(ang - (QUARTER_CENTRE[q] << ANGLE_FRAC_BITS));
      if (d <= band && d >= -band) return q;
      best = q;
      near_off = FULL_TURN;
      for (int k = 0; k < 4; k++) begin
         off = wrap_half_turn(ang - (QUARTER_CENTRE[k] << ANGLE_FRAC_BITS));
         if (off < 0) off = -off;
         if (off < near_off) begin
            near_off = off;
            best = k[1:0];
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      logic [1:0] want;
      int delta;
      delta = 0;
      if (reset) begin
         min_mag <= MIN_MAG_RESET;
         hys_band <= HYS_RESET;
         expected_quarters.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_MAGNITUDE: min_mag <= csr_data[MIN_MAG_W-1:0];
               CSR_HYSTERESIS_ANGLE: hys_band <= csr_data[HYS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_quarters.push_back(predict_quarter(req_accel_x, req_accel_y,
               req_current_quarter, min_mag, hys_band));
            delta = delta + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_quarters.size() == 0) begin
               $display("%0t: new_quarter expected none, actual %0d", $time, rsp_new_quarter);
               mismatches = mismatches + 1;
            end else begin
               want = expected_quarters.pop_front();
               delta = delta - 1;
               if (rsp_new_quarter !== want) begin
                  $display("%0t: new_quarter expected %0d, actual %0d",
                     $time, want, rsp_new_quarter);
                  mismatches = mismatches + 1;
               end
            end
         end
         outstanding <= outstanding + delta;
      end
   end

endmodule

[test/tilt_quarter_hysteresis_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_quarter_hysteresis_tb
// Drives accelerometer samples and register settings into the tilt quarter
// block with random gaps and result stalls; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tilt_quarter_hysteresis_tb;
   import thq_pkg::*;

   localparam int LATENCY = CORDIC_STAGES_DEF + 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [15:0]    req_accel_x = '0;
   logic signed [15:0]    req_accel_y = '0;
   logic [2:0]            req_current_quarter = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [1:0]            rsp_new_quarter;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending_count;
   int gap_pct = 20;
   int stall_pct = 5;
   int cur_min = 4096;
   int cur_hys = 2560;

   tilt_quarter_hysteresis u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_current_quarter(req_current_quarter),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_quarter    (rsp_new_quarter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   thq_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_current_quarter(req_current_quarter),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_quarter    (rsp_new_quarter),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (fail_count),
      .outstanding        (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic [2:0] cq);
      int gap;
      req_valid <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_current_quarter <= cq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic load_settings(input logic [MIN_MAG_W-1:0] mm, input logic [HYS_W-1:0] hy);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_MIN_MAGNITUDE;
      csr_data <= mm;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_HYSTERESIS_ANGLE;
      csr_data <= {1'b0, hy};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_min = mm;
      cur_hys = hy;
   endtask

   // result side: hold ready low for random stretches
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
         end
      end
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int mode, m, a, d, r, k;
      logic signed [15:0] sx, sy;
      logic [2:0] cq;
      real theta;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(16'sd0, 16'sd0, 3'd0);
      send_sample(16'sd32767, 16'sd0, 3'd5);
      send_sample(16'sd0, 16'sd32767, 3'd0);
      send_sample(-16'sd32768, 16'sd0, 3'd0);
      send_sample(16'sd0, -16'sd32768, 3'd3);
      send_sample(16'sd32767, 16'sd32767, 3'd1);
      send_sample(-16'sd32768, -16'sd32768, 3'd7);
      send_sample(-16'sd32768, 16'sd32767, 3'd2);
      send_sample(16'sd32767, -16'sd32768, 3'd6);
      send_sample(16'sd4095, 16'sd0, 3'd2);
      send_sample(16'sd4096, 16'sd0, 3'd2);
      send_sample(16'sd20000, 16'sd20000, 3'd2);
      send_sample(-16'sd20000, 16'sd20000, 3'd1);
      send_sample(-16'sd1, -16'sd1, 3'd4);

      load_settings(15'd0, 14'd11520);
      send_sample(16'sd0, 16'sd0, 3'd1);
      send_sample(16'sd0, 16'sd0, 3'd2);
      send_sample(16'sd1, 16'sd0, 3'd3);
      send_sample(16'sd0, -16'sd1, 3'd0);
      send_sample(-16'sd1, 16'sd0, 3'd0);

      load_settings(15'd32767, 14'd0);
      send_sample(-16'sd32768, 16'sd0, 3'd0);
      send_sample(16'sd32767, 16'sd0, 3'd3);
      send_sample(16'sd23170, 16'sd23170, 3'd0);
      send_sample(-16'sd32768, -16'sd32768, 3'd3);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: load_settings(15'd32767, 14'd11520);
            1: load_settings(15'd0, 14'd0);
            3: load_settings(15'd0, 14'd11520);
            4: load_settings(15'd32767, 14'd0);
            default: load_settings(15'($urandom_range(0, 32767)),
                                   14'($urandom_range(0, 11520)));
         endcase
         if (p == 2) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = $urandom_range(5, 40);
            stall_pct = $urandom_range(2, 15);
         end
         for (int n = 0; n < 80; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 30) begin
               sx = 16'($urandom);
               sy = 16'($urandom);
            end else if (mode < 50) begin
               m = cur_min + 1;
               sx = 16'(int'($urandom_range(0, 2 * m)) - m);
               sy = 16'(int'($urandom_range(0, 2 * m)) - m);
            end else if (mode < 70) begin
               a = $urandom_range(0, 32767);
               d = $urandom_range(0, 8) - 4;
               sx = 16'(($urandom_range(0, 1) != 0) ? -a : a);
               sy = 16'(($urandom_range(0, 1) != 0) ? -(a + d) : (a + d));
            end else if (mode < 90) begin
               k = $urandom_range(0, 3);
               theta = k * 90.0 + (($urandom_range(0, 1) != 0) ? 1.0 : -1.0)
                  * (45.0 + cur_hys / 256.0) + ($urandom_range(0, 200) - 100) / 100.0;
               r = $urandom_range(3000, 32000);
               sx = 16'($rtoi(r * $cos(theta * 3.14159265358979 / 180.0)));
               sy = 16'($rtoi(r * $sin(theta * 3.14159265358979 / 180.0)));
            end else begin
               a = $urandom_range(16384, 32767);
               d = $urandom_range(0, 64) - 32;
               if ($urandom_range(0, 1) != 0) begin
                  sx = 16'(($urandom_range(0, 1) != 0) ? -a - 1 : a);
                  sy = 16'(d);
               end else begin
                  sx = 16'(d);
                  sy = 16'(($urandom_range(0, 1) != 0) ? -a - 1 : a);
               end
            end
            cq = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3))
                                               : 3'($urandom_range(4, 7));
            send_sample(sx, sy, cq);
            if ($urandom_range(0, 99) == 0) drain();
         end
      end

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/thq_pkg.sv
rtl/core/thq_prep.sv
rtl/core/thq_cell.sv
rtl/core/thq_decide.sv
rtl/core/tilt_quarter_hysteresis.sv
test/thq_checker.sv
test/tilt_quarter_hysteresis_tb.sv
